// ===== rtl/core/fud_pkg.sv =====
`timescale 1ns / 1ps

package fud_pkg;

	// Characters with a special meaning in a form body
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
	localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
	localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

	// Result kinds
	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Escape progress
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	// Most results one body byte can cause
	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} fud_res_t;

	typedef struct packed {
		fud_res_t [MAX_RES-1:0] slot;
		logic [2:0]             cnt;
	} fud_list_t;

	typedef struct packed {
		logic       in_value;
		logic [1:0] pend;
		logic [7:0] held;
		logic       trunc;
	} fud_state_t;

	// Hex digit of either case: valid flag and nibble
	function automatic logic [4:0] fud_hex(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Append one result to a list, dropping anything past the last slot
	function automatic fud_list_t fud_put(input fud_list_t l, input logic [7:0] b,
			input logic [1:0] k);
		fud_list_t r;
		r = l;
		if (l.cnt < 3'(MAX_RES)) begin
			r.slot[l.cnt[1:0]].data = b;
			r.slot[l.cnt[1:0]].kind = k;
			r.slot[l.cnt[1:0]].last = 1'b0;
			r.cnt = l.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/fud_decode.sv =====
`timescale 1ns / 1ps

// Decodes one body byte against the current parse state: builds the list
// of results it causes and the next state.
module fud_decode (
	input  logic [7:0]          c,
	input  logic                last,
	input  fud_pkg::fud_state_t st,
	output fud_pkg::fud_list_t  res,
	output fud_pkg::fud_state_t st_nxt
);
	import fud_pkg::*;

	always_comb begin
		fud_list_t  l;
		fud_state_t s;
		logic [4:0] hx;
		logic [4:0] hh;
		logic [7:0] v;
		logic       fresh;

		l = '0;
		s = st;
		hx = fud_hex(c);
		hh = fud_hex(st.held);
		v = {hh[3:0], hx[3:0]};
		fresh = 1'b0;

		// Escape in progress, or plain byte
		if (s.pend == PEND_PCT) begin
			if (hx[4]) begin
				s.held = c;
				s.pend = PEND_DIGIT;
			end else begin
				l = fud_put(l, CH_PCT, s.in_value ? KIND_VALUE : KIND_KEY);
				s.pend = PEND_NONE;
				fresh = 1'b1;
			end
		end else if (s.pend == PEND_DIGIT) begin
			if (hx[4]) begin
				s.pend = PEND_NONE;
				if (v == 8'd0) begin
					s.trunc = 1'b1;
				end else begin
					l = fud_put(l, v, s.in_value ? KIND_VALUE : KIND_KEY);
				end
			end else begin
				l = fud_put(l, CH_PCT, s.in_value ? KIND_VALUE : KIND_KEY);
				l = fud_put(l, s.held, s.in_value ? KIND_VALUE : KIND_KEY);
				s.pend = PEND_NONE;
				fresh = 1'b1;
			end
		end else begin
			s.pend = PEND_NONE;
			fresh = 1'b1;
		end

		// Byte taken on its own
		if (fresh) begin
			if (c == CH_AMP) begin
				l = fud_put(l, 8'd0, KIND_END);
				s.in_value = 1'b0;
				s.trunc = 1'b0;
			end else if (c == CH_EQ && !s.in_value) begin
				s.in_value = 1'b1;
				s.trunc = 1'b0;
			end else if (!s.trunc) begin
				if (c == CH_PLUS) begin
					l = fud_put(l, CH_SPACE, s.in_value ? KIND_VALUE : KIND_KEY);
				end else if (c == CH_PCT) begin
					s.pend = PEND_PCT;
				end else if (c == 8'd0) begin
					s.trunc = 1'b1;
				end else begin
					l = fud_put(l, c, s.in_value ? KIND_VALUE : KIND_KEY);
				end
			end
		end

		// End of body: close open escape and pair, then back to reset state
		if (last) begin
			if (c != CH_AMP) begin
				if (s.pend == PEND_PCT) begin
					l = fud_put(l, CH_PCT, s.in_value ? KIND_VALUE : KIND_KEY);
				end else if (s.pend == PEND_DIGIT) begin
					l = fud_put(l, CH_PCT, s.in_value ? KIND_VALUE : KIND_KEY);
					l = fud_put(l, s.held, s.in_value ? KIND_VALUE : KIND_KEY);
				end
				l = fud_put(l, 8'd0, KIND_END);
			end
			s = '0;
			if (l.cnt != 3'd0) begin
				l.slot[2'(l.cnt - 3'd1)].last = 1'b1;
			end
		end

		res = l;
		st_nxt = s;
	end

endmodule

// ===== rtl/core/fud_res_buf.sv =====
`timescale 1ns / 1ps

// Result buffer: holds the results of one byte and hands them out one beat
// per cycle while the receiver is ready, head always in slot 0.
module fud_res_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  fud_pkg::fud_list_t list_in,
	output logic               can_load,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]         m_axis_tuser,   // [1:0] kind
	output logic               m_axis_tlast    // out_last
);
	import fud_pkg::*;

	fud_res_t [MAX_RES-1:0] slot_q;
	logic [2:0]             cnt_q;
	logic                   pop;

	assign pop      = m_axis_tvalid && m_axis_tready;
	assign can_load = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready);

	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tdata  = slot_q[0].data;
	assign m_axis_tuser  = slot_q[0].kind;
	assign m_axis_tlast  = slot_q[0].last;

	// Count of results still to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= list_in.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Result slots: load a new list or shift toward the head
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= list_in.slot;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MAX_RES))
		else $error("result count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && pop)))
		else $error("result list loaded over unsent results");

	a_last_is_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (cnt_q == 3'd1))
		else $error("tlast beat is not the final buffered result");

endmodule

// ===== rtl/core/form_urlencoded_decoder.sv =====
`timescale 1ns / 1ps

// Path: a body byte is held in the input register and decoded, and its results
//   are loaded into the result buffer, which presents them on the master side.
// Throughput: one byte per cycle while each byte yields at most one result and
//   the receiver is ready; a byte yielding N results (up to 4) stalls the input while they are sent.
// Reset: arst_n clears parse state, input register and result buffer.
module form_urlencoded_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
	input  logic       s_axis_tlast,   // body_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // out_last
);
	import fud_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	fud_state_t st_q;
	fud_state_t st_nxt;
	fud_list_t  res;
	logic       can_load;
	logic       advance;

	assign advance       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	fud_decode u_decode (
		.c      (byte_s1),
		.last   (last_s1),
		.st     (st_q),
		.res    (res),
		.st_nxt (st_nxt)
	);

	fud_res_buf u_res_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.list_in       (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_body_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (st_q == '0))
		else $error("parse state not cleared after last body byte");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> (res.cnt != 3'd0))
		else $error("last body byte produced no result");

endmodule

// ===== test/form_urlencoded_decoder_chk.sv =====
`timescale 1ns / 1ps

// Watches both sides of the form decoder, predicts the decoded beats of every
// accepted body byte and compares them in order with what the master side
// delivers.
module form_urlencoded_decoder_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
	input  logic       s_axis_tlast,   // body_last
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
	input  logic [1:0] m_axis_tuser,   // [1:0] kind
	input  logic       m_axis_tlast,   // out_last
	output int         fail_count,
	output int         owed_count
);
	import fud_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} beat_t;

	beat_t owed_beats[$];   // decoded beats still to come out
	beat_t step_beats[$];   // beats caused by the byte being decoded

	// Parser state
	logic       in_value;
	logic [1:0] pend;
	logic [7:0] held_digit;
	logic       trunc;

	task automatic report(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		fail_count++;
	endtask

	// {valid, nibble} for a hex digit of either case
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b1, 4'(c - 8'h30)};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return {1'b1, 4'(c - 8'h57)};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return {1'b1, 4'(c - 8'h37)};
		end
		return 5'd0;
	endfunction

	task automatic clear_parser();
		in_value   = 1'b0;
		pend       = PEND_NONE;
		held_digit = 8'h00;
		trunc      = 1'b0;
	endtask

	task automatic put_beat(input logic [7:0] b, input logic [1:0] k);
		beat_t nb;
		nb.data = b;
		nb.kind = k;
		nb.last = 1'b0;
		if (step_beats.size() < MAX_RES) begin
			step_beats.push_back(nb);
		end
	endtask

	task automatic put_char(input logic [7:0] b);
		put_beat(b, in_value ? KIND_VALUE : KIND_KEY);
	endtask

	// An open escape goes out literally
	task automatic flush_escape();
		if (pend == PEND_PCT) begin
			put_char(CH_PCT);
		end else if (pend == PEND_DIGIT) begin
			put_char(CH_PCT);
			put_char(held_digit);
		end
		pend = PEND_NONE;
	endtask

	task automatic close_pair();
		put_beat(8'h00, KIND_END);
		in_value = 1'b0;
		trunc    = 1'b0;
	endtask

	// Byte seen with no escape open
	task automatic plain_byte(input logic [7:0] c);
		if (c == CH_AMP) begin
			close_pair();
		end else if (c == CH_EQ && !in_value) begin
			in_value = 1'b1;
			trunc    = 1'b0;
		end else if (!trunc) begin
			if (c == CH_PLUS) begin
				put_char(CH_SPACE);
			end else if (c == CH_PCT) begin
				pend = PEND_PCT;
			end else if (c == 8'h00) begin
				trunc = 1'b1;
			end else begin
				put_char(c);
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic is_last);
		logic [4:0] lo;
		logic [4:0] hi;
		logic [7:0] v;
		step_beats.delete();
		lo = hex_nibble(c);
		case (pend)
			PEND_PCT: begin
				if (lo[4]) begin
					held_digit = c;
					pend       = PEND_DIGIT;
				end else begin
					flush_escape();
					plain_byte(c);
				end
			end
			PEND_DIGIT: begin
				if (lo[4]) begin
					hi   = hex_nibble(held_digit);
					v    = {hi[3:0], lo[3:0]};
					pend = PEND_NONE;
					if (v == 8'h00) begin
						trunc = 1'b1;
					end else begin
						put_char(v);
					end
				end else begin
					flush_escape();
					plain_byte(c);
				end
			end
			default: begin
				pend = PEND_NONE;
				plain_byte(c);
			end
		endcase

		// Body end: close the open pair unless the last byte already did
		if (is_last) begin
			if (c != CH_AMP) begin
				flush_escape();
				close_pair();
			end
			clear_parser();
			if (step_beats.size() > 0) begin
				step_beats[step_beats.size() - 1].last = 1'b1;
			end
		end
		foreach (step_beats[i]) begin
			owed_beats.push_back(step_beats[i]);
		end
	endtask

	// Predict on slave beats, compare on master beats
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			clear_parser();
			owed_beats.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_beats.size() == 0) begin
					report($sformatf("unexpected beat data %h kind %0d last %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = owed_beats.pop_front();
					if (m_axis_tdata !== want.data) begin
						report($sformatf("out_byte got %h want %h", m_axis_tdata, want.data));
					end
					if (m_axis_tuser !== want.kind) begin
						report($sformatf("kind got %0d want %0d", m_axis_tuser, want.kind));
					end
					if (m_axis_tlast !== want.last) begin
						report($sformatf("out_last got %b want %b", m_axis_tlast, want.last));
					end
				end
			end
		end
		owed_count = owed_beats.size();
	end

endmodule

// ===== test/form_urlencoded_decoder_tb.sv =====
`timescale 1ns / 1ps

module form_urlencoded_decoder_tb;
	import fud_pkg::*;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h01;   // [7:0] body_byte
	logic       s_axis_tlast  = 1'b0;    // body_last
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [7:0] out_byte
	logic [1:0] m_axis_tuser;            // [1:0] kind
	logic       m_axis_tlast;            // out_last

	bit         stall_en = 1'b1;
	int         fail_count;
	int         owed_count;
	int         bytes_sent;
	logic [7:0] body_q[$];
	string      hex_chars  = "0123456789abcdefABCDEF";
	string      word_chars = "abcXYZ019_-.~*";

	form_urlencoded_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	form_urlencoded_decoder_chk u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.owed_count    (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver stalls at random
	always @(negedge clk) begin
		m_axis_tready <= !(stall_en && $urandom_range(99) < 11);
	end

	// One body beat; returns at the falling edge after it was taken
	task automatic push_byte(input logic [7:0] b, input logic is_last);
		while (stall_en && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i], i == s.len() - 1);
		end
	endtask

	task automatic send_body();
		foreach (body_q[i]) begin
			push_byte(body_q[i], i == body_q.size() - 1);
		end
	endtask

	task automatic add_hex();
		body_q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
	endtask

	// Key or value text: plain chars, '+', escapes, broken escapes, '=' in values, stray bytes
	task automatic add_part(input bit is_value);
		int r;
		repeat ($urandom_range(4)) begin
			r = $urandom_range(99);
			if (r < 40) begin
				body_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
			end else if (r < 52) begin
				body_q.push_back(CH_PLUS);
			end else if (r < 78) begin
				body_q.push_back(CH_PCT);
				if ($urandom_range(7) == 0) begin
					body_q.push_back(8'h30);
					body_q.push_back(8'h30);
				end else begin
					add_hex();
					add_hex();
				end
			end else if (r < 88) begin
				body_q.push_back(CH_PCT);
				if ($urandom_range(1)) begin
					add_hex();
				end
			end else if (r < 93 && is_value) begin
				body_q.push_back(CH_EQ);
			end else begin
				body_q.push_back(8'($urandom_range(255, 1)));
			end
		end
	endtask

	task automatic build_body();
		int r;
		body_q.delete();
		if ($urandom_range(9) == 0) begin
			// noise body
			repeat ($urandom_range(8, 1)) begin
				r = $urandom_range(9);
				case (r)
					0: body_q.push_back(CH_AMP);
					1: body_q.push_back(CH_EQ);
					2: body_q.push_back(CH_PCT);
					3: add_hex();
					default: body_q.push_back(8'($urandom_range(255, 1)));
				endcase
			end
		end else begin
			if ($urandom_range(7) == 0) begin
				body_q.push_back(CH_AMP);
			end
			for (int p = $urandom_range(3, 1); p > 0; p--) begin
				add_part(1'b0);
				if ($urandom_range(4) != 0) begin
					body_q.push_back(CH_EQ);
					add_part(1'b1);
				end
				if (p > 1) begin
					body_q.push_back(CH_AMP);
					if ($urandom_range(7) == 0) begin
						body_q.push_back(CH_AMP);
					end
				end
			end
			if ($urandom_range(5) == 0) begin
				body_q.push_back(CH_AMP);
			end
		end
		if (body_q.size() == 0) begin
			body_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
		end
	endtask

	initial begin
		int n_body;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Leading '&', held digit open at body end
		send_text("&K%4");
		// Escape right before '=', '+', bare '%' open at body end
		send_text("%4a=+%");
		// Decoded zero cuts the key, '=' in the value, escape right at body end
		send_text("%00a==%5e");
		// Top byte value, escape before '&', doubled '&', body ends on '&'
		send_text("x=%FF&&");
		// Escape cut short by another '%'
		send_text("%4%");
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b1);

		// Random bodies, with a stretch free of stalls in the middle
		n_body = 0;
		while (bytes_sent < 420) begin
			stall_en = !(n_body >= 10 && n_body < 18);
			build_body();
			send_body();
			n_body++;
		end
		stall_en = 1'b1;
		s_axis_tvalid <= 1'b0;

		while (owed_count != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
